// File: rtl/annexb_pkg.sv
// Shared types, constants and the report builder for the Annex B NAL unit splitter.
// Used by annexb_nal_unit_splitter; depends on nothing else.
package annexb_pkg;

    // Width of the running unit byte counter.
    localparam int LENGTH_BITS = 24;
    // Width of the reported unit length.
    localparam int UNIT_LENGTH_W = 24;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    // Byte values that make up a start code.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    // NAL unit type codes that the classification looks at.
    localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;
    localparam logic [4:0] NAL_TYPE_SEI   = 5'd6;
    localparam logic [4:0] NAL_TYPE_SPS   = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS   = 5'd8;
    localparam logic [4:0] NAL_TYPE_AUD   = 5'd9;

    // One finished unit as it leaves the block.
    typedef struct packed {
        logic [UNIT_LENGTH_W-1:0] unit_length;
        logic                     length_saturated;
        logic                     forbidden_flag;
        logic [1:0]               reference_idc;
        logic [4:0]               unit_type;
        logic                     key_frame;
        logic                     config_frame;
        logic                     droppable;
        logic                     decodable;
        logic                     closed_by_end;
    } nal_report_t;

    // Builds a report from the captured header bytes and the final length.
    function automatic nal_report_t build_report(
        input logic [7:0]             header_byte,
        input logic [7:0]             second_byte,
        input logic [LENGTH_BITS-1:0] len,
        input logic                   sat,
        input logic                   by_end
    );
        nal_report_t rep;
        logic [4:0]  nal_type;
        logic        dec;
        nal_type = header_byte[4:0];
        dec = (len >= LENGTH_BITS'(2)) && (nal_type >= NAL_TYPE_SLICE) &&
              (nal_type <= NAL_TYPE_IDR) && second_byte[7];
        rep.unit_length      = UNIT_LENGTH_W'(len);
        rep.length_saturated = sat;
        rep.forbidden_flag   = header_byte[7];
        rep.reference_idc    = header_byte[6:5];
        rep.unit_type        = nal_type;
        rep.key_frame        = (nal_type == NAL_TYPE_IDR) && dec;
        rep.config_frame     = (nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS);
        rep.droppable        = (nal_type == NAL_TYPE_SEI) || (nal_type == NAL_TYPE_AUD);
        rep.decodable        = dec;
        rep.closed_by_end    = by_end;
        return rep;
    endfunction

endpackage

// File: rtl/annexb_nal_unit_splitter.sv
// Annex B NAL unit splitter: start code search, unit length count and header classification.
// Depends on annexb_pkg for the counter width, type codes and the report builder.
//
// Usage:
//   The input channel (s_valid, s_ready, s_data_byte, s_end_of_stream) takes one
//   word per byte of an H.264 Annex B byte stream. Bytes before the first start
//   code are dropped. Each NAL unit is reported once on the result channel
//   (m_valid, m_ready and the m_ report fields) when the next start code, or a
//   word marked end of stream, closes it. Units of zero length are not reported.
//   A report is registered into the output register from the closing word, or into
//   the skid register while the output is held. Throughput: one word per cycle
//   while s_ready is high; the scanner state is updated from the accepted word.
//   The result side is a two-entry output register plus skid register, so the
//   block keeps taking words while one report waits; s_ready drops only while
//   the skid register holds a second report, and rises the cycle after the
//   receiver takes one.
//   Reset (aresetn low, synchronous) empties both result registers and returns
//   the scanner to the search for the first start code. The block also returns
//   to that state after every word marked end of stream.
module annexb_nal_unit_splitter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_end_of_stream,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [annexb_pkg::UNIT_LENGTH_W-1:0] m_unit_length,
    output logic                               m_length_saturated,
    output logic                               m_forbidden_flag,
    output logic [1:0]                         m_reference_idc,
    output logic [4:0]                         m_unit_type,
    output logic                               m_key_frame,
    output logic                               m_config_frame,
    output logic                               m_droppable,
    output logic                               m_decodable,
    output logic                               m_closed_by_end
);
    import annexb_pkg::*;

    // Scanner state.
    logic [23:0]            recent_reg, recent_next;
    logic                   inside_reg, inside_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [7:0]             header_reg, header_next;
    logic [7:0]             second_reg, second_next;
    logic                   ovf_reg, ovf_next;

    // Result registers: output stage and skid stage.
    logic                   m_valid_reg, m_valid_next;
    nal_report_t            m_data_reg, m_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    nal_report_t            skid_data_reg, skid_data_next;

    logic                   s_fire;
    logic                   start_code;
    logic                   res_valid;
    nal_report_t            res_data;
    logic [LENGTH_BITS-1:0] strip;
    logic [LENGTH_BITS-1:0] start_len;

    assign s_ready    = ~skid_valid_reg;
    assign s_fire     = s_valid & s_ready;
    assign start_code = (recent_reg[15:0] == {BYTE_ZERO, BYTE_ZERO}) &&
                        (s_data_byte == BYTE_ONE);

    // A three-byte start code removes two counted zeros, a four-byte one three.
    assign strip = (recent_reg[23:16] == BYTE_ZERO) ? LENGTH_BITS'(3) : LENGTH_BITS'(2);
    always_comb begin
        if (ovf_reg) begin
            start_len = COUNT_MAX;
        end else if (count_reg > strip) begin
            start_len = count_reg - strip;
        end else begin
            start_len = '0;
        end
    end

    // Scanner update for one accepted word and the report it may close.
    always_comb begin
        recent_next = recent_reg;
        inside_next = inside_reg;
        count_next  = count_reg;
        header_next = header_reg;
        second_next = second_reg;
        ovf_next    = ovf_reg;
        res_valid   = 1'b0;
        res_data    = build_report(header_reg, second_reg, start_len, ovf_reg, 1'b0);

        if (s_fire) begin
            if (start_code) begin
                // Close the open unit, then open a fresh one.
                res_valid   = inside_reg && ((start_len != '0) || ovf_reg);
                inside_next = 1'b1;
                count_next  = '0;
                header_next = '0;
                second_next = '0;
                ovf_next    = 1'b0;
                recent_next = '1;
            end else begin
                if (inside_reg) begin
                    if (count_reg == LENGTH_BITS'(0)) begin
                        header_next = s_data_byte;
                    end else if (count_reg == LENGTH_BITS'(1)) begin
                        second_next = s_data_byte;
                    end
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + LENGTH_BITS'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                recent_next = {recent_reg[15:0], s_data_byte};
            end

            // End of stream flushes an open unit with all its bytes and resets.
            if (s_end_of_stream) begin
                if (inside_next && !res_valid && ((count_next != '0) || ovf_next)) begin
                    res_valid = 1'b1;
                    res_data  = build_report(header_next, second_next,
                                             ovf_next ? COUNT_MAX : count_next,
                                             ovf_next, 1'b1);
                end
                recent_next = '1;
                inside_next = 1'b0;
                count_next  = '0;
                header_next = '0;
                second_next = '0;
                ovf_next    = 1'b0;
            end
        end
    end

    // Output register with a skid stage behind it.
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = res_valid;
                m_data_next  = res_data;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg     <= '1;
            inside_reg     <= 1'b0;
            count_reg      <= '0;
            header_reg     <= '0;
            second_reg     <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            recent_reg     <= recent_next;
            inside_reg     <= inside_next;
            count_reg      <= count_next;
            header_reg     <= header_next;
            second_reg     <= second_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_unit_length      = m_data_reg.unit_length;
    assign m_length_saturated = m_data_reg.length_saturated;
    assign m_forbidden_flag   = m_data_reg.forbidden_flag;
    assign m_reference_idc    = m_data_reg.reference_idc;
    assign m_unit_type        = m_data_reg.unit_type;
    assign m_key_frame        = m_data_reg.key_frame;
    assign m_config_frame     = m_data_reg.config_frame;
    assign m_droppable        = m_data_reg.droppable;
    assign m_decodable        = m_data_reg.decodable;
    assign m_closed_by_end    = m_data_reg.closed_by_end;

`ifndef SYNTHESIS
    // The skid stage is only filled behind a held output word.
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a report while the output is empty");

    // A report can only come from an open unit.
    a_report_needs_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> inside_reg)
        else $error("report produced while searching for a start code");

    // After an end-of-stream word the scanner is back in its search state.
    a_eos_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_end_of_stream) |=> (!inside_reg && (recent_reg == 24'hFFFFFF)))
        else $error("scanner not reset after end of stream");

    // The overflow flag is only set with a saturated counter.
    a_overflow_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == COUNT_MAX))
        else $error("overflow flag set below the counter maximum");
`endif

endmodule

// File: dv/tb_annexb_nal_unit_splitter.sv
// Testbench for annexb_nal_unit_splitter: drives Annex B byte streams with random stalls
// and checks every NAL unit report against a cycle-free model of the splitter.
// Depends on annexb_pkg and the annexb_nal_unit_splitter RTL.
`timescale 1ns / 100ps

module tb_annexb_nal_unit_splitter;
    import annexb_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int TAIL_CYCLES       = 8;
    localparam int LONG_STALL_CYCLES = 300;

    // One row of the directed stimulus; typed rows carry their own expected report.
    typedef struct {
        logic [7:0]  data;
        logic        eos;
        bit          typed;
        nal_report_t rep;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_data_byte = '0;
    logic                     s_end_of_stream = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [UNIT_LENGTH_W-1:0] m_unit_length;
    logic                     m_length_saturated;
    logic                     m_forbidden_flag;
    logic [1:0]               m_reference_idc;
    logic [4:0]               m_unit_type;
    logic                     m_key_frame;
    logic                     m_config_frame;
    logic                     m_droppable;
    logic                     m_decodable;
    logic                     m_closed_by_end;

    // Model state of the start code scanner.
    logic [23:0]            scan_window;
    logic                   in_unit;
    logic [LENGTH_BITS-1:0] unit_bytes;
    logic [7:0]             hdr_byte;
    logic [7:0]             sec_byte;
    logic                   unit_overflow;

    nal_report_t  expected_units[$];
    stim_row_t    directed_rows[$];
    int unsigned  words_sent = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    bit           long_stall_pending = 1'b0;

    annexb_nal_unit_splitter i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_end_of_stream    (s_end_of_stream),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_unit_length      (m_unit_length),
        .m_length_saturated (m_length_saturated),
        .m_forbidden_flag   (m_forbidden_flag),
        .m_reference_idc    (m_reference_idc),
        .m_unit_type        (m_unit_type),
        .m_key_frame        (m_key_frame),
        .m_config_frame     (m_config_frame),
        .m_droppable        (m_droppable),
        .m_decodable        (m_decodable),
        .m_closed_by_end    (m_closed_by_end)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Scanner back to the search for the first start code.
    task automatic clear_splitter();
        scan_window   = '1;
        in_unit       = 1'b0;
        unit_bytes    = '0;
        hdr_byte      = '0;
        sec_byte      = '0;
        unit_overflow = 1'b0;
    endtask

    // Header fields and classification flags of the unit that is being closed.
    function automatic nal_report_t unit_report(input logic [LENGTH_BITS-1:0] len,
                                                input logic sat, input logic by_end);
        nal_report_t rep;
        logic [4:0]  nal_type;
        logic        dec;
        nal_type = hdr_byte[4:0];
        dec = (len >= 2) && (nal_type >= NAL_TYPE_SLICE) && (nal_type <= NAL_TYPE_IDR) &&
              sec_byte[7];
        rep.unit_length      = UNIT_LENGTH_W'(len);
        rep.length_saturated = sat;
        rep.forbidden_flag   = hdr_byte[7];
        rep.reference_idc    = hdr_byte[6:5];
        rep.unit_type        = nal_type;
        rep.key_frame        = dec && (nal_type == NAL_TYPE_IDR);
        rep.config_frame     = (nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS);
        rep.droppable        = (nal_type == NAL_TYPE_SEI) || (nal_type == NAL_TYPE_AUD);
        rep.decodable        = dec;
        rep.closed_by_end    = by_end;
        return rep;
    endfunction

    // Advances the scanner by one accepted word and tells whether a unit was closed.
    task automatic advance_splitter(input logic [7:0] b, input logic eos,
                                    output bit made, output nal_report_t rep);
        logic                   is_start;
        logic [LENGTH_BITS-1:0] strip;
        logic [LENGTH_BITS-1:0] len;
        made = 1'b0;
        rep = '0;
        is_start = (scan_window[15:0] == {BYTE_ZERO, BYTE_ZERO}) && (b == BYTE_ONE);
        if (is_start) begin
            // The zeros of the start code were counted into the unit; take them back out.
            if (in_unit) begin
                strip = (scan_window[23:16] == BYTE_ZERO) ? LENGTH_BITS'(3)
                                                          : LENGTH_BITS'(2);
                if (unit_overflow) begin
                    len = COUNT_MAX;
                end else begin
                    len = (unit_bytes > strip) ? unit_bytes - strip : '0;
                end
                if (len != 0 || unit_overflow) begin
                    rep = unit_report(len, unit_overflow, 1'b0);
                    made = 1'b1;
                end
            end
            in_unit       = 1'b1;
            unit_bytes    = '0;
            hdr_byte      = '0;
            sec_byte      = '0;
            unit_overflow = 1'b0;
            scan_window   = '1;
        end else begin
            if (in_unit) begin
                if (unit_bytes == 0) begin
                    hdr_byte = b;
                end else if (unit_bytes == 1) begin
                    sec_byte = b;
                end
                if (unit_bytes != COUNT_MAX) begin
                    unit_bytes++;
                end else begin
                    unit_overflow = 1'b1;
                end
            end
            scan_window = {scan_window[15:0], b};
        end
        // End of stream flushes the open unit with its trailing zeros.
        if (eos) begin
            if (in_unit && !made && (unit_bytes != 0 || unit_overflow)) begin
                rep = unit_report(unit_overflow ? COUNT_MAX : unit_bytes, unit_overflow, 1'b1);
                made = 1'b1;
            end
            clear_splitter();
        end
    endtask

    // Offers one word, waits for its acceptance and records what it should produce.
    task automatic send_word(input logic [7:0] b, input logic eos, input bit typed = 1'b0,
                             input nal_report_t typed_rep = '0);
        bit          made;
        nal_report_t rep;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        advance_splitter(b, eos, made, rep);
        if (typed) begin
            expected_units.push_back(typed_rep);
        end else if (made) begin
            expected_units.push_back(rep);
        end
    endtask

    // Stops offering words and lets every outstanding report come out.
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic eos, input bit typed = 1'b0,
                           input nal_report_t rep = '0);
        stim_row_t row;
        row.data  = b;
        row.eos   = eos;
        row.typed = typed;
        row.rep   = rep;
        directed_rows.push_back(row);
    endtask

    // Report of a directed row, never saturated.
    function automatic nal_report_t typed_report(input int len, input logic forb,
                                                 input logic [1:0] idc, input logic [4:0] ty,
                                                 input logic key, input logic cfg,
                                                 input logic drop, input logic dec,
                                                 input logic by_end);
        nal_report_t rep;
        rep.unit_length      = UNIT_LENGTH_W'(len);
        rep.length_saturated = 1'b0;
        rep.forbidden_flag   = forb;
        rep.reference_idc    = idc;
        rep.unit_type        = ty;
        rep.key_frame        = key;
        rep.config_frame     = cfg;
        rep.droppable        = drop;
        rep.decodable        = dec;
        rep.closed_by_end    = by_end;
        return rep;
    endfunction

    // Stream byte with zeros and ones favored so that start codes turn up by chance.
    function automatic logic [7:0] stream_byte(input int unsigned zero_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) begin
            return BYTE_ZERO;
        end else if (r < zero_pct + 8) begin
            return BYTE_ONE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed units with random content, the rest stray bytes.
    task automatic send_random_stream(input int unsigned n_words);
        int unsigned target;
        int unsigned body_len;
        int unsigned r;
        int unsigned k;
        logic [7:0]  b;
        bit          eos_here;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_word(BYTE_ZERO, 1'b0);
                end
                send_word(BYTE_ZERO, 1'b0);
                send_word(BYTE_ZERO, 1'b0);
                send_word(BYTE_ONE, 1'b0);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    body_len = 0;
                end else if (r < 40) begin
                    body_len = $urandom_range(1, 3);
                end else if (r < 90) begin
                    body_len = $urandom_range(4, 16);
                end else begin
                    body_len = $urandom_range(17, 60);
                end
                eos_here = ($urandom_range(0, 99) < 8);
                for (k = 0; k < body_len; k++) begin
                    if (k == 0) begin
                        b[7:5] = 3'($urandom_range(0, 7));
                        b[4:0] = ($urandom_range(0, 99) < 60) ? 5'($urandom_range(1, 9))
                                                              : 5'($urandom_range(0, 31));
                    end else if (k == 1) begin
                        b = 8'($urandom_range(0, 255));
                    end else begin
                        b = stream_byte(20);
                    end
                    send_word(b, eos_here && (k == body_len - 1));
                end
            end else begin
                body_len = $urandom_range(1, 8);
                for (k = 0; k < body_len; k++) begin
                    send_word(stream_byte(40), $urandom_range(0, 99) < 10);
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker: every report taken by the receiver against the oldest expectation.
    always @(posedge aclk) begin
        nal_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                $error("unexpected report: unit_length %0d, unit_type %0d",
                       m_unit_length, m_unit_type);
                mismatch_count++;
            end else begin
                want = expected_units.pop_front();
                check_field("unit_length", want.unit_length, m_unit_length);
                check_field("length_saturated", want.length_saturated, m_length_saturated);
                check_field("forbidden_flag", want.forbidden_flag, m_forbidden_flag);
                check_field("reference_idc", want.reference_idc, m_reference_idc);
                check_field("unit_type", want.unit_type, m_unit_type);
                check_field("key_frame", want.key_frame, m_key_frame);
                check_field("config_frame", want.config_frame, m_config_frame);
                check_field("droppable", want.droppable, m_droppable);
                check_field("decodable", want.decodable, m_decodable);
                check_field("closed_by_end", want.closed_by_end, m_closed_by_end);
            end
        end
    end

    // Receiver: random back-pressure, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (long_stall_pending) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge aclk);
                long_stall_pending = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        clear_splitter();

        // Directed stream. Bytes before the first start code are dropped, then an IDR
        // slice closed by a four-byte start code, a one-byte PPS unit, an empty unit,
        // a slice closed by end of stream with a trailing zero, a start code that ends
        // the stream and a stray byte that ends the stream before any start code.
        add_row(8'h55, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0);
        add_row(8'h65, 1'b0);
        add_row(8'h88, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0, 1'b1, typed_report(3, 1'b0, 2'd3, NAL_TYPE_IDR,
                                                1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        add_row(8'hE8, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0, 1'b1, typed_report(1, 1'b1, 2'd3, NAL_TYPE_PPS,
                                                1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0);
        add_row(8'h21, 1'b0);
        add_row(8'h80, 1'b0);
        add_row(8'h00, 1'b1, 1'b1, typed_report(3, 1'b0, 2'd1, NAL_TYPE_SLICE,
                                                1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b1);
        add_row(8'h12, 1'b1);

        send_idle_pct = 15;
        recv_idle_pct = 80;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].typed,
                      directed_rows[i].rep);
        end
        drain_reports();

        // Random streams: slow receiver, then slow sender.
        send_random_stream(520);
        drain_reports();
        send_idle_pct = 80;
        recv_idle_pct = 15;
        send_random_stream(520);
        drain_reports();

        // Full rate, opening with a long receiver hold-off so the input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_stall_pending = 1'b1;
        send_random_stream(560);
        drain_reports();

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/annexb_pkg.sv
rtl/annexb_nal_unit_splitter.sv
dv/tb_annexb_nal_unit_splitter.sv
